@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VXS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define VXS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/vxs_pkg.sv @@
// ----------------------------------------------------------------------------
// vxs_pkg
// Types and constants shared by the voxel store and its coordinate decoder.
// ----------------------------------------------------------------------------
package vxs_pkg;

    localparam int IN_W  = 40;   // input tdata width, whole bytes
    localparam int OUT_W = 88;   // output tdata width, whole bytes
    localparam int TOP_W = 11;   // signed column top width

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_WAIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic col_ok;   // x and z inside the grid
        logic ok;       // x, y and z inside the grid
    } t_decode_flags;

    // result item, first field in the highest bits
    typedef struct packed {
        logic                    dirty;
        logic [31:0]             write_count;
        logic [31:0]             change_count;
        logic signed [TOP_W-1:0] column_top;
        logic                    in_range;
        logic [7:0]              read_value;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

@@ rtl/voxel_store_with_column_heightmap.sv @@
// ----------------------------------------------------------------------------
// voxel_store_with_column_heightmap
// 3D byte grid with a per-column height map, change/write counters and dirty.
// ----------------------------------------------------------------------------
// The input transfer fills the item and memory read registers; the execute
// state then does the read-modify-write and loads the output register, or
// holds the result until it is free. No new item is taken before idle.
// Writing empty exactly at a column top above the bottom row adds a downward scan, one cell-memory read per cycle.
// Reset: synchronous; a clearing pass over all 2^(XW+ZW+YW) cell addresses
// (65536 by default) zeroes both memories while s_tready stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_store_with_column_heightmap #(
    parameter int SIZE_X = 16,
    parameter int SIZE_Z = 16,
    parameter int MIN_Y  = 0,
    parameter int MAX_Y  = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // slave side
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pos_x[7:0], pos_y[17:8], pos_z[25:18], write_value[33:26], zero pad
    input  logic [vxs_pkg::IN_W-1:0]   s_tdata,
    // opcode[0]
    input  logic [0:0]                 s_tuser,
    // master side
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_value[7:0], in_range[8], column_top[19:9], change_count[51:20],
    // write_count[83:52], dirty[84], zero pad
    output logic [vxs_pkg::OUT_W-1:0]  m_tdata
);
    import vxs_pkg::*;

    // Geometry. Cells sit at {x, z, y - MIN_Y}, each field padded to a power
    // of two, so an address is a plain concatenation.
    localparam int HEIGHT = MAX_Y - MIN_Y;
    localparam int XW     = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
    localparam int ZW     = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
    localparam int YW     = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int HW     = $clog2(HEIGHT + 1);  // top + 1 - MIN_Y, 0 = empty
    localparam int CW     = XW + ZW;
    localparam int AW     = CW + YW;

    // Height map entries hold h = top - MIN_Y + 1, so an empty column is 0
    // and the clearing pass writes zeros into both memories.
    function automatic logic signed [TOP_W-1:0] f_top(input logic [HW-1:0] h);
        f_top = $signed(TOP_W'(h)) + TOP_W'(MIN_Y - 1);
    endfunction

    // ------------------------------------------------------------------
    // Coordinate decode straight off the slave port
    // ------------------------------------------------------------------
    t_decode_flags w_dec_flags;
    logic [CW-1:0] w_dec_col;
    logic [YW-1:0] w_dec_yoff;

    vxs_decode #(
        .SIZE_X (SIZE_X),
        .SIZE_Z (SIZE_Z),
        .MIN_Y  (MIN_Y),
        .MAX_Y  (MAX_Y)
    ) u_decode (
        .i_pos_x (s_tdata[7:0]),
        .i_pos_y (s_tdata[17:8]),
        .i_pos_z (s_tdata[25:18]),
        .o_flags (w_dec_flags),
        .o_col   (w_dec_col),
        .o_yoff  (w_dec_yoff)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state        r_state,     n_state;
    logic [AW-1:0] r_clr_addr,  n_clr_addr;
    logic [31:0]   r_change_cnt, n_change_cnt;
    logic [31:0]   r_write_cnt, n_write_cnt;
    logic          r_dirty,     n_dirty;
    logic          r_out_valid, n_out_valid;
    logic          r_chk_vld,   n_chk_vld;
    t_result       r_out,       n_out;
    t_result       r_pend,      n_pend;
    logic [YW-1:0] r_scan_y,    n_scan_y;
    logic [YW-1:0] r_chk_y,     n_chk_y;

    // captured item
    t_decode_flags r_flags;
    logic [CW-1:0] r_col;
    logic [YW-1:0] r_yoff;
    logic          r_is_write;
    logic [7:0]    r_wval;

    // memories and their registered read data
    logic [7:0]    cell_mem [2**AW];
    logic [HW-1:0] top_mem  [2**CW];
    logic [7:0]    r_cell_q;
    logic [HW-1:0] r_top_q;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_out_free;

    assign s_tready   = (r_state == ST_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    // output register empty, or its item leaves on this edge
    assign w_out_free = !r_out_valid || m_tready;

    // ------------------------------------------------------------------
    // Execute cycle: read data of the item is in r_cell_q / r_top_q
    // ------------------------------------------------------------------
    logic          w_do_write;
    logic [HW-1:0] w_yo_ext;
    logic [HW-1:0] w_yo_inc;
    logic          w_raise;      // non-empty write above the top
    logic          w_clear_top;  // empty write exactly on the top
    logic          w_scan_start;
    logic [HW-1:0] w_h_new;
    t_result       w_exec_res;

    assign w_do_write   = r_flags.ok && (r_is_write == OP_WRITE);
    assign w_yo_ext     = HW'(r_yoff);
    assign w_yo_inc     = w_yo_ext + HW'(1);
    assign w_raise      = w_do_write && (r_wval != 8'd0) && (w_yo_ext >= r_top_q);
    assign w_clear_top  = w_do_write && (r_wval == 8'd0) && (w_yo_inc == r_top_q);
    // the top cell itself is now empty; cells above it always were, so the
    // search starts one below. Nothing to search under the bottom row.
    assign w_scan_start = w_clear_top && (r_yoff != YW'(0));
    assign w_h_new      = w_raise     ? w_yo_inc :
                          w_clear_top ? HW'(0)   : r_top_q;

    assign n_change_cnt = r_change_cnt
                        + 32'((w_do_write && (r_cell_q != r_wval)) ? 1 : 0);
    assign n_write_cnt  = r_write_cnt + 32'(w_do_write ? 1 : 0);
    assign n_dirty      = r_dirty | w_do_write;

    always_comb begin
        w_exec_res.read_value   = (r_flags.ok && (r_is_write == OP_READ)) ? r_cell_q : 8'd0;
        w_exec_res.in_range     = r_flags.ok;
        w_exec_res.column_top   = r_flags.col_ok ? f_top(w_h_new) : TOP_W'(MIN_Y - 1);
        w_exec_res.change_count = n_change_cnt;
        w_exec_res.write_count  = n_write_cnt;
        w_exec_res.dirty        = n_dirty;
    end

    // ------------------------------------------------------------------
    // Column scan: one read issued per cycle, r_chk_y names the row whose
    // data sits in r_cell_q
    // ------------------------------------------------------------------
    logic          w_found;
    logic          w_bottom;
    logic          w_scan_done;
    logic [HW-1:0] w_h_scan;
    t_result       w_scan_res;

    assign w_found     = r_chk_vld && (r_cell_q != 8'd0);
    assign w_bottom    = r_chk_vld && (r_chk_y == YW'(0));
    assign w_scan_done = w_found || w_bottom;
    assign w_h_scan    = w_found ? (HW'(r_chk_y) + HW'(1)) : HW'(0);

    always_comb begin
        w_scan_res            = r_pend;
        w_scan_res.column_top = f_top(w_h_scan);
    end

    // ------------------------------------------------------------------
    // Memory port control
    // ------------------------------------------------------------------
    logic          w_cell_we;
    logic [AW-1:0] w_cell_waddr;
    logic [7:0]    w_cell_wdata;
    logic          w_cell_re;
    logic [AW-1:0] w_cell_raddr;
    logic          w_top_we;
    logic [CW-1:0] w_top_waddr;
    logic [HW-1:0] w_top_wdata;

    always_comb begin
        w_cell_we    = 1'b0;
        w_cell_waddr = {r_col, r_yoff};
        w_cell_wdata = r_wval;
        w_top_we     = 1'b0;
        w_top_waddr  = r_col;
        w_top_wdata  = w_h_new;
        unique case (r_state)
            ST_CLEAR: begin
                w_cell_we    = 1'b1;
                w_cell_waddr = r_clr_addr;
                w_cell_wdata = 8'd0;
                w_top_we     = 1'b1;
                w_top_waddr  = r_clr_addr[CW-1:0];
                w_top_wdata  = HW'(0);
            end
            ST_EXEC: begin
                w_cell_we = w_do_write;
                w_top_we  = w_raise || (w_clear_top && !w_scan_start);
            end
            ST_SCAN: begin
                w_top_we    = w_scan_done;
                w_top_wdata = w_h_scan;
            end
            ST_IDLE, ST_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    assign w_cell_re    = w_accept || (r_state == ST_SCAN);
    assign w_cell_raddr = (r_state == ST_SCAN) ? {r_col, r_scan_y}
                                               : {w_dec_col, w_dec_yoff};

    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            cell_mem[w_cell_waddr] <= w_cell_wdata;
        end
        if (w_cell_re) begin
            r_cell_q <= cell_mem[w_cell_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_top_we) begin
            top_mem[w_top_waddr] <= w_top_wdata;
        end
        if (w_accept) begin
            r_top_q <= top_mem[w_dec_col];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !m_tready;
        n_out       = r_out;
        n_pend      = r_pend;
        n_scan_y    = r_scan_y;
        n_chk_y     = r_chk_y;
        n_chk_vld   = r_chk_vld;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == {AW{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_scan_start) begin
                    n_pend    = w_exec_res;
                    n_scan_y  = r_yoff - YW'(1);
                    n_chk_vld = 1'b0;
                    n_state   = ST_SCAN;
                end else if (w_out_free) begin
                    n_out       = w_exec_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_pend  = w_exec_res;
                    n_state = ST_WAIT;
                end
            end
            ST_SCAN: begin
                // read below is issued every cycle; a wrapped read after the
                // bottom row is never looked at
                n_chk_y   = r_scan_y;
                n_chk_vld = 1'b1;
                n_scan_y  = r_scan_y - YW'(1);
                if (w_scan_done) begin
                    if (w_out_free) begin
                        n_out       = w_scan_res;
                        n_out_valid = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_pend  = w_scan_res;
                        n_state = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (w_out_free) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_change_cnt <= '0;
            r_write_cnt  <= '0;
            r_dirty      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_chk_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
            if (r_state == ST_EXEC) begin
                r_change_cnt <= n_change_cnt;
                r_write_cnt  <= n_write_cnt;
                r_dirty      <= n_dirty;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_pend   <= n_pend;
        r_scan_y <= n_scan_y;
        r_chk_y  <= n_chk_y;
        if (w_accept) begin
            r_flags    <= w_dec_flags;
            r_col      <= w_dec_col;
            r_yoff     <= w_dec_yoff;
            r_is_write <= s_tuser[0];
            r_wval     <= s_tdata[33:26];
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_W - RES_W){1'b0}}, r_out};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VXS_ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, r_state == ST_EXEC)
    `VXS_ASSERT_NEXT(a_wcnt_moves_in_exec, r_state != ST_EXEC, $stable(r_write_cnt))
    `VXS_ASSERT_NEXT(a_scan_needs_write, (r_state == ST_EXEC) && !r_flags.ok, r_state != ST_SCAN)

endmodule

@@ rtl/vxs_decode.sv @@
// ----------------------------------------------------------------------------
// vxs_decode
// Range checks and memory address fields for one cell coordinate.
// ----------------------------------------------------------------------------
module vxs_decode #(
    parameter int  SIZE_X = 16,
    parameter int  SIZE_Z = 16,
    parameter int  MIN_Y  = 0,
    parameter int  MAX_Y  = 256,
    localparam int HEIGHT = MAX_Y - MIN_Y,
    localparam int XW     = (SIZE_X > 1) ? $clog2(SIZE_X) : 1,
    localparam int ZW     = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1,
    localparam int YW     = (HEIGHT > 1) ? $clog2(HEIGHT) : 1
) (
    input  logic [7:0]              i_pos_x,
    input  logic [9:0]              i_pos_y,
    input  logic [7:0]              i_pos_z,
    output vxs_pkg::t_decode_flags  o_flags,
    output logic [XW+ZW-1:0]        o_col,
    output logic [YW-1:0]           o_yoff
);
    import vxs_pkg::*;

    logic signed [10:0] w_yo;   // y - MIN_Y
    logic               w_x_ok;
    logic               w_z_ok;
    logic               w_y_ok;

    assign w_yo   = 11'($signed(i_pos_y)) - 11'(MIN_Y);
    assign w_x_ok = !i_pos_x[7] && (i_pos_x[6:0] < 7'(SIZE_X));
    assign w_z_ok = !i_pos_z[7] && (i_pos_z[6:0] < 7'(SIZE_Z));
    assign w_y_ok = !w_yo[10] && (w_yo[9:0] < 10'(HEIGHT));

    assign o_flags.col_ok = w_x_ok && w_z_ok;
    assign o_flags.ok     = w_x_ok && w_z_ok && w_y_ok;
    assign o_col          = {i_pos_x[XW-1:0], i_pos_z[ZW-1:0]};
    assign o_yoff         = w_yo[YW-1:0];

endmodule

@@ tb/voxel_store_with_column_heightmap_tb.sv @@
// ----------------------------------------------------------------------------
// voxel_store_with_column_heightmap_tb
// Self-checking bench for the voxel store. Accesses are generated up front and
// queued for a stream driver. A monitor updates a shadow grid and height map
// on every input transfer and checks each output transfer against it.
// ----------------------------------------------------------------------------
module voxel_store_with_column_heightmap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vxs_pkg::*;

    localparam int SIZE_X    = 16;
    localparam int SIZE_Z    = 16;
    localparam int MIN_Y     = 0;
    localparam int MAX_Y     = 256;
    localparam int HEIGHT    = MAX_Y - MIN_Y;
    localparam int NCELLS    = SIZE_X * SIZE_Z * HEIGHT;
    localparam int EMPTY_TOP = MIN_Y - 1;
    localparam int N_RANDOM  = 1800;

    // one voxel access as it travels on the input stream
    typedef struct {
        logic       op;
        logic [7:0] x;
        logic [9:0] y;
        logic [7:0] z;
        logic [7:0] value;
    } t_voxel_access;

    logic            i_clk    = 1'b0;
    logic            i_rst_n  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    // pos_x[7:0], pos_y[17:8], pos_z[25:18], write_value[33:26], zero pad
    logic [IN_W-1:0] s_tdata  = '0;
    // opcode[0]
    logic [0:0]      s_tuser  = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // read_value[7:0], in_range[8], column_top[19:9], change_count[51:20],
    // write_count[83:52], dirty[84], zero pad
    logic [OUT_W-1:0] m_tdata;

    voxel_store_with_column_heightmap #(
        .SIZE_X (SIZE_X),
        .SIZE_Z (SIZE_Z),
        .MIN_Y  (MIN_Y),
        .MAX_Y  (MAX_Y)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shadow state: the grid, the column tops, the two counters and dirty.
    // ------------------------------------------------------------------------
    logic [7:0]  cell_image [0:NCELLS-1];
    int          top_image  [0:SIZE_X*SIZE_Z-1];
    logic [31:0] change_tally = '0;
    logic [31:0] write_tally  = '0;
    logic        dirty_seen   = 1'b0;

    t_voxel_access pending_accesses [$];   // not yet offered to the block
    t_result       expected_results [$];   // predicted, awaiting output transfer
    t_voxel_access on_bus;                 // access currently offered
    int            n_items   = 0;
    int            n_sent    = 0;
    int            n_errors  = 0;
    logic          in_fire   = 1'b0;       // input transfer at the last edge
    logic          hold_off  = 1'b0;       // long receiver back-pressure
    int            src_gap   = 0;
    int            sink_stall = 0;

    task automatic report(input string msg);
        n_errors++;
        $display("%0t ns: mismatch, %s", $time, msg);
    endtask

    // Apply one access to the shadow state and return the result it yields.
    function automatic t_result apply_access(t_voxel_access a);
        int      x, y, z, col, idx, yy;
        bit      col_ok, ok, found;
        t_result res;
        x      = int'($signed(a.x));
        y      = int'($signed(a.y));
        z      = int'($signed(a.z));
        col_ok = x >= 0 && x < SIZE_X && z >= 0 && z < SIZE_Z;
        ok     = col_ok && y >= MIN_Y && y < MAX_Y;
        col    = col_ok ? x * SIZE_Z + z : 0;
        res    = '0;
        if (ok) begin
            idx = col * HEIGHT + (y - MIN_Y);
            if (a.op == OP_READ) begin
                res.read_value = cell_image[idx];
            end else begin
                if (cell_image[idx] != a.value)
                    change_tally++;
                cell_image[idx] = a.value;
                write_tally++;
                dirty_seen = 1'b1;
                if (a.value == 8'd0) begin
                    // clearing at or above the top: walk down for the new top
                    if (y >= top_image[col]) begin
                        found = 1'b0;
                        top_image[col] = EMPTY_TOP;
                        for (yy = MAX_Y - 1; yy >= MIN_Y && !found; yy--) begin
                            if (cell_image[col * HEIGHT + yy - MIN_Y] != 8'd0) begin
                                top_image[col] = yy;
                                found = 1'b1;
                            end
                        end
                    end
                end else if (y > top_image[col]) begin
                    top_image[col] = y;
                end
            end
        end
        res.in_range     = ok;
        res.column_top   = TOP_W'(col_ok ? top_image[col] : EMPTY_TOP);
        res.change_count = change_tally;
        res.write_count  = write_tally;
        res.dirty        = dirty_seen;
        return res;
    endfunction

    function automatic void queue_access(logic op, int x, int y, int z, int v);
        t_voxel_access a;
        a.op    = op;
        a.x     = x[7:0];
        a.y     = y[9:0];
        a.z     = z[7:0];
        a.value = v[7:0];
        pending_accesses.push_back(a);
    endfunction

    // Mostly well-formed accesses packed into a few hot columns, so tops rise
    // and get cleared often; the rest is raw noise and out-of-range heights.
    function automatic t_voxel_access random_access();
        t_voxel_access a;
        int            p, q;
        p       = $urandom_range(0, 99);
        a.op    = ($urandom_range(0, 9) < 6) ? OP_WRITE : OP_READ;
        a.value = ($urandom_range(0, 9) < 4) ? 8'd0 : 8'($urandom_range(1, 255));
        if (p < 7) begin
            a.x = 8'($urandom_range(0, 255));
            a.y = 10'($urandom_range(0, 1023));
            a.z = 8'($urandom_range(0, 255));
            a.value = 8'($urandom_range(0, 255));
        end else begin
            if ($urandom_range(0, 9) < 7) begin
                a.x = 8'($urandom_range(0, 2));
                a.z = 8'($urandom_range(0, 2));
            end else begin
                a.x = 8'($urandom_range(0, SIZE_X - 1));
                a.z = 8'($urandom_range(0, SIZE_Z - 1));
            end
            q = $urandom_range(0, 9);
            if (p < 12)
                a.y = $urandom_range(0, 1) ? 10'($urandom_range(MAX_Y, 511))
                                           : 10'(-int'($urandom_range(1, 512)));
            else if (q < 4)
                a.y = 10'(MAX_Y - 1 - int'($urandom_range(0, 5)));
            else if (q < 7)
                a.y = 10'(MIN_Y + int'($urandom_range(0, 5)));
            else
                a.y = 10'(MIN_Y + int'($urandom_range(0, HEIGHT - 1)));
        end
        return a;
    endfunction

    // No idling in the tail, and in one of every four stretches of 150 items.
    function automatic bit steady_phase();
        return pending_accesses.size() < 250 ||
               ((pending_accesses.size() / 150) % 4) == 3;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: a new access goes out at the falling edge once the last one
    // has been taken (or nothing was on offer), with random gaps between.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || in_fire)) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap--;
            end else if (pending_accesses.size() != 0) begin
                on_bus = pending_accesses.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'b0, on_bus.value, on_bus.z, on_bus.y, on_bus.x};
                s_tuser  <= on_bus.op;
                // keep feeding during the long hold-off so the block backs up
                if (!steady_phase() && !hold_off && $urandom_range(0, 3) == 0)
                    src_gap = $urandom_range(1, 9);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready by default, stalls at random outside steady phases and throughout the hold-off.
    always @(negedge i_clk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_tready <= 1'b1;
            if (!steady_phase() && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 9);
        end
    end

    // One long back-pressure stretch, well into the random part.
    initial begin
        while (n_sent < 400)
            @(negedge i_clk);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each input transfer, checks each output transfer
    // against the oldest prediction, field by field.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result got, want;
        in_fire <= s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready) begin
            expected_results.push_back(apply_access(on_bus));
            n_sent++;
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[RES_W-1:0];
            if (expected_results.size() == 0) begin
                report("output transfer with no access outstanding");
            end else begin
                want = expected_results.pop_front();
                if (got.read_value !== want.read_value)
                    report($sformatf("read_value got %0d want %0d",
                                     got.read_value, want.read_value));
                if (got.in_range !== want.in_range)
                    report($sformatf("in_range got %0b want %0b",
                                     got.in_range, want.in_range));
                if (got.column_top !== want.column_top)
                    report($sformatf("column_top got %0d want %0d",
                                     $signed(got.column_top), $signed(want.column_top)));
                if (got.change_count !== want.change_count)
                    report($sformatf("change_count got %0d want %0d",
                                     got.change_count, want.change_count));
                if (got.write_count !== want.write_count)
                    report($sformatf("write_count got %0d want %0d",
                                     got.write_count, want.write_count));
                if (got.dirty !== want.dirty)
                    report($sformatf("dirty got %0b want %0b", got.dirty, want.dirty));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NCELLS; i++)
            cell_image[i] = 8'd0;
        for (int i = 0; i < SIZE_X * SIZE_Z; i++)
            top_image[i] = EMPTY_TOP;

        // corners of the grid, tops rising, falling and emptying
        queue_access(OP_READ,  0, 0, 0, 0);
        queue_access(OP_WRITE, 0, 0, 0, 255);
        queue_access(OP_WRITE, 0, 0, 0, 255);            // same value again
        queue_access(OP_WRITE, 0, MAX_Y - 1, 0, 1);      // top to the ceiling
        queue_access(OP_READ,  0, MAX_Y - 1, 0, 0);
        queue_access(OP_WRITE, 0, MAX_Y - 1, 0, 0);      // clear top, scan down
        queue_access(OP_WRITE, 0, MIN_Y, 0, 0);          // column now empty
        queue_access(OP_WRITE, 0, 10, 0, 0);             // empty onto empty
        queue_access(OP_WRITE, SIZE_X - 1, 100, SIZE_Z - 1, 8'h80);
        queue_access(OP_WRITE, SIZE_X - 1, 50, SIZE_Z - 1, 7);   // below top
        queue_access(OP_WRITE, SIZE_X - 1, 50, SIZE_Z - 1, 0);   // clear below top
        queue_access(OP_READ,  SIZE_X - 1, 50, SIZE_Z - 1, 0);
        // out of range in each coordinate; ignored writes
        queue_access(OP_READ,  -128, 0, 0, 0);
        queue_access(OP_WRITE, 127, 5, 5, 8'hAA);
        queue_access(OP_READ,  SIZE_X, 0, 0, 0);
        queue_access(OP_READ,  0, 0, -1, 0);
        queue_access(OP_WRITE, 0, 0, SIZE_Z, 1);
        queue_access(OP_READ,  SIZE_X - 1, -512, SIZE_Z - 1, 0); // only y out
        queue_access(OP_WRITE, SIZE_X - 1, 511, SIZE_Z - 1, 8'h55);
        queue_access(OP_READ,  SIZE_X - 1, MAX_Y, SIZE_Z - 1, 0);
        queue_access(OP_WRITE, SIZE_X - 1, MIN_Y - 1, SIZE_Z - 1, 3);
        queue_access(OP_WRITE, -1, -1, -128, 8'hFF);
        queue_access(OP_READ,  SIZE_X - 1, 100, SIZE_Z - 1, 0);
        queue_access(OP_WRITE, SIZE_X - 1, 100, SIZE_Z - 1, 0);  // full scan to empty

        for (int i = 0; i < N_RANDOM; i++)
            pending_accesses.push_back(random_access());
        n_items = pending_accesses.size();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // the block clears its memories first; the driver just waits on ready
        while (!(n_sent == n_items && expected_results.size() == 0))
            @(negedge i_clk);
        // room for a stray late transfer, a full column scan included
        repeat (300) @(negedge i_clk);

        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hang guard: clearing pass plus worst-case scans and stalls, with margin.
    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
